@@ sv/tilt_heading_alignment_check_macros.svh @@
// ============================================================================
// Tilt and heading alignment check: assertion macros
// Concurrent assertion wrappers used by the RTL; they compile away under
// synthesis. The module that uses them must have clk and rst_n in scope.
// ============================================================================
`ifndef TILT_HEADING_ALIGNMENT_CHECK_MACROS_SVH
`define TILT_HEADING_ALIGNMENT_CHECK_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define THA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tha assertion failed");
// Next-cycle implication.
`define THA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tha assertion failed");
`else
`define THA_ASSERT_IMPL(label, ante, cons)
`define THA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ sv/tha_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Tilt and heading alignment check: shared package
// Widths, angle constants, register indexes, the arctangent table and the
// types that pass between the front end, the queue and the back end.
// ============================================================================
package tha_pkg;

    localparam int IN_W          = 16;
    localparam int SUM_W         = 17;
    localparam int SQR_W         = 33;
    localparam int SQ_W          = 34;
    localparam int ROOT_W        = 32;
    localparam int SQRT_STEPS    = 32;
    localparam int SQ_PRESHIFT   = 30;
    localparam int REM_W         = 36;
    localparam int Q15_SHIFT     = 15;
    localparam int CORD_W        = 36;
    localparam int ATAN_FRAC     = 8;
    localparam int ANG_W         = 25;
    localparam int ANGLE_W       = ANG_W - ATAN_FRAC;
    localparam int WRAP_W        = 18;
    localparam int PITCH_W       = 15;
    localparam int HEAD_W        = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int FIFO_DEPTH    = 2;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int HALF_TURN     = 18000;
    localparam int FULL_TURN     = 36000;
    localparam int PITCH_LIMIT   = 9000;
    localparam int HALF_TURN_Q8  = HALF_TURN * (1 << ATAN_FRAC);
    localparam int ROUND_HALF    = 1 << (ATAN_FRAC - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X    = 3'd0,
        CFG_OFFSET_Y    = 3'd1,
        CFG_OFFSET_Z    = 3'd2,
        CFG_DECLINATION = 3'd3,
        CFG_LATITUDE    = 3'd4,
        CFG_PITCH_TOL   = 3'd5,
        CFG_HEADING_TOL = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic signed [15:0] offset_z;
        logic signed [15:0] declination;
        logic signed [14:0] latitude;
        logic        [13:0] pitch_tol;
        logic        [14:0] heading_tol;
    } cfg_t;

    typedef struct packed {
        logic        [SQ_W-1:0]  sq;
        logic signed [SUM_W-1:0] ax;
        logic signed [SUM_W-1:0] mx;
        logic signed [SUM_W-1:0] my;
    } tha_item_t;

    // Arctangent of 2^-i in centidegrees, Q8.
    function automatic logic signed [ANG_W-1:0] atan_q8(input int unsigned idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:       v = ANG_W'(1152000);
            1:       v = ANG_W'(680065);
            2:       v = ANG_W'(359328);
            3:       v = ANG_W'(182400);
            4:       v = ANG_W'(91554);
            5:       v = ANG_W'(45822);
            6:       v = ANG_W'(22916);
            7:       v = ANG_W'(11459);
            8:       v = ANG_W'(5730);
            9:       v = ANG_W'(2865);
            10:      v = ANG_W'(1432);
            11:      v = ANG_W'(716);
            12:      v = ANG_W'(358);
            13:      v = ANG_W'(179);
            14:      v = ANG_W'(90);
            15:      v = ANG_W'(45);
            16:      v = ANG_W'(22);
            17:      v = ANG_W'(11);
            18:      v = ANG_W'(6);
            19:      v = ANG_W'(3);
            20:      v = ANG_W'(1);
            21:      v = ANG_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/tha_ifs.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Tilt and heading alignment check: channel interfaces
// Valid/ready channels for raw sensor samples and for alignment results.
// ============================================================================
interface tha_sample_if;
    logic                              valid;
    logic                              ready;
    logic signed [tha_pkg::IN_W-1:0]   accel_x;
    logic signed [tha_pkg::IN_W-1:0]   accel_y;
    logic signed [tha_pkg::IN_W-1:0]   accel_z;
    logic signed [tha_pkg::IN_W-1:0]   mag_x;
    logic signed [tha_pkg::IN_W-1:0]   mag_y;

    modport source (output valid, accel_x, accel_y, accel_z, mag_x, mag_y, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, mag_x, mag_y, output ready);
endinterface

interface tha_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [tha_pkg::PITCH_W-1:0]  pitch_cdeg;
    logic signed [tha_pkg::HEAD_W-1:0]   heading_cdeg;
    logic                                pitch_ok;
    logic                                heading_ok;
    logic                                all_ok;

    modport source (output valid, pitch_cdeg, heading_cdeg, pitch_ok, heading_ok, all_ok,
                    input ready);
    modport sink   (input valid, pitch_cdeg, heading_cdeg, pitch_ok, heading_ok, all_ok,
                    output ready);
endinterface

@@ sv/tilt_heading_alignment_check.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Tilt and heading alignment check: top level
// Computes pitch and declination-corrected heading of a raw sensor sample
// and flags whether the mount is aligned to the configured site.
//
//   Channel   Direction  Handshake       Payload
//   sample    in         valid/ready     accel_x, accel_y, accel_z, mag_x, mag_y
//   result    out        valid/ready     pitch_cdeg, heading_cdeg, pitch_ok,
//                                        heading_ok, all_ok
//   cfg       in         cfg_we          cfg_index, cfg_data (no read-back)
//
// One sample transaction is taken every cycle when the result side keeps up;
// each sample yields exactly one result transaction.
// The path runs through three front stages, the queue, 32 square-root
// stages, CORDIC_STEPS + 1 CORDIC stages and two finishing stages including
// the output register.
// Reset clears all valid flags, the queue pointers and the configuration registers.
// The front end and the back end each stall only on their own downstream;
// the queue between them absorbs the difference.
// ============================================================================
module tilt_heading_alignment_check #(
    parameter int CORDIC_STEPS = tha_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tha_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tha_pkg::CFG_DATA_W-1:0]   cfg_data,
    tha_sample_if.sink                       sample,
    tha_result_if.source                     result
);
    import tha_pkg::*;

    cfg_t      cfg_reg;
    logic      f_valid, f_ready, q_valid, q_ready;
    tha_item_t f_item, q_item;

    // Register bank. The user must write only while the block is idle; the block itself
    // does not enforce this. The pipeline reads these registers directly. Unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_OFFSET_X:    cfg_reg.offset_x    <= cfg_data;
                CFG_OFFSET_Y:    cfg_reg.offset_y    <= cfg_data;
                CFG_OFFSET_Z:    cfg_reg.offset_z    <= cfg_data;
                CFG_DECLINATION: cfg_reg.declination <= cfg_data;
                CFG_LATITUDE:    cfg_reg.latitude    <= cfg_data[14:0];
                CFG_PITCH_TOL:   cfg_reg.pitch_tol   <= cfg_data[13:0];
                CFG_HEADING_TOL: cfg_reg.heading_tol <= cfg_data[14:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Front end: offsets and sum of squares.
    tha_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .cfg        (cfg_reg),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    // Queue that decouples the two halves.
    tha_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // Back end: square root, angles, windows and output register.
    tha_back #(.STEPS(CORDIC_STEPS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .cfg        (cfg_reg),
        .result     (result)
    );

endmodule

@@ sv/tha_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Tilt and heading alignment check: front end
// Accepts samples, applies offsets, squares the pitch axes and forms the
// sum of squares, in three stages that advance together.
// ============================================================================
module tha_front (
    input  logic               clk,
    input  logic               rst_n,
    tha_sample_if.sink         sample,
    input  tha_pkg::cfg_t      cfg,
    output logic               item_valid,
    input  logic               item_ready,
    output tha_pkg::tha_item_t item
);
    import tha_pkg::*;

    logic adv;
    logic va_reg, vb_reg, vc_reg;

    logic signed [SUM_W-1:0] ax_a_reg, ay_a_reg, az_a_reg, mx_a_reg, my_a_reg;
    logic signed [SUM_W-1:0] ax_b_reg, mx_b_reg, my_b_reg;
    logic        [SQR_W-1:0] ay_sq_reg, az_sq_reg;
    logic signed [2*SUM_W-1:0] ay_prod, az_prod;
    tha_item_t item_reg;

    assign adv          = !vc_reg || item_ready;
    assign sample.ready = adv;
    assign item_valid   = vc_reg;
    assign item         = item_reg;

    assign ay_prod = ay_a_reg * ay_a_reg;
    assign az_prod = az_a_reg * az_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= sample.valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_a_reg <= SUM_W'(sample.accel_x) + SUM_W'(cfg.offset_x);
            ay_a_reg <= SUM_W'(sample.accel_y) + SUM_W'(cfg.offset_y);
            az_a_reg <= SUM_W'(sample.accel_z) + SUM_W'(cfg.offset_z);
            mx_a_reg <= SUM_W'(sample.mag_x) + SUM_W'(cfg.offset_x);
            my_a_reg <= SUM_W'(sample.mag_y) + SUM_W'(cfg.offset_y);

            ax_b_reg  <= ax_a_reg;
            mx_b_reg  <= mx_a_reg;
            my_b_reg  <= my_a_reg;
            ay_sq_reg <= ay_prod[SQR_W-1:0];
            az_sq_reg <= az_prod[SQR_W-1:0];

            item_reg.sq <= SQ_W'(ay_sq_reg) + SQ_W'(az_sq_reg);
            item_reg.ax <= ax_b_reg;
            item_reg.mx <= mx_b_reg;
            item_reg.my <= my_b_reg;
        end
    end

endmodule

@@ sv/tha_fifo.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Tilt and heading alignment check: decoupling queue
// Small first-in first-out buffer between the front end and the back end.
// ============================================================================
`include "tilt_heading_alignment_check_macros.svh"

module tha_fifo #(
    parameter int DEPTH = tha_pkg::FIFO_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tha_pkg::tha_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output tha_pkg::tha_item_t out_item
);
    import tha_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tha_item_t mem [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    `THA_ASSERT_NEXT(a_fifo_grow, push && !pop, count_reg == $past(count_reg) + CNT_W'(1))
    `THA_ASSERT_NEXT(a_fifo_shrink, pop && !push, count_reg == $past(count_reg) - CNT_W'(1))
    `THA_ASSERT_NEXT(a_fifo_hold, out_valid && !out_ready, out_item == $past(out_item))

endmodule

@@ sv/tha_cordic.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Tilt and heading alignment check: pipelined vectoring CORDIC
// atan2(y, x) in centidegrees, one iteration per stage after a half-turn
// pre-rotation stage. Advances when en is high.
// ============================================================================
module tha_cordic #(
    parameter int STEPS = tha_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [tha_pkg::CORD_W-1:0]   x_in,
    input  logic signed [tha_pkg::CORD_W-1:0]   y_in,
    output logic signed [tha_pkg::ANGLE_W-1:0]  angle
);
    import tha_pkg::*;

    localparam logic signed [ANG_W-1:0] HALF_Q8 = ANG_W'(HALF_TURN_Q8);

    logic signed [CORD_W-1:0] x_reg [0:STEPS];
    logic signed [CORD_W-1:0] y_reg [0:STEPS];
    logic signed [ANG_W-1:0]  z_reg [0:STEPS];
    logic                     zero_reg [0:STEPS];
    logic signed [ANG_W-1:0]  z_round;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                z_reg[0] <= (y_in >= 0) ? HALF_Q8 : -HALF_Q8;
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q8(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q8(i);
                end
            end
        end
    end

    // Round half up to whole centidegrees; a zero vector gives zero.
    assign z_round = z_reg[STEPS] + ANG_W'(ROUND_HALF);
    assign angle   = zero_reg[STEPS] ? '0 : z_round[ANG_W-1:ATAN_FRAC];

endmodule

@@ sv/tha_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Tilt and heading alignment check: back end
// Square root of the pitch denominator, two CORDIC pipelines, heading
// correction and the alignment windows, ending in the output register.
// ============================================================================
`include "tilt_heading_alignment_check_macros.svh"

module tha_back #(
    parameter int STEPS = tha_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  tha_pkg::tha_item_t item,
    input  tha_pkg::cfg_t      cfg,
    tha_result_if.source       result
);
    import tha_pkg::*;

    localparam int LAST = SQRT_STEPS - 1;
    localparam logic signed [WRAP_W-1:0]  HALF_W  = WRAP_W'(HALF_TURN);
    localparam logic signed [WRAP_W-1:0]  FULL_W  = WRAP_W'(FULL_TURN);
    localparam logic signed [ANGLE_W-1:0] HALF_A  = ANGLE_W'(HALF_TURN);
    localparam logic signed [ANGLE_W-1:0] PLIM_A  = ANGLE_W'(PITCH_LIMIT);

    function automatic logic signed [WRAP_W-1:0] wrap_once(input logic signed [WRAP_W-1:0] a);
        logic signed [WRAP_W-1:0] r;
        r = a;
        if (a > HALF_W)
        begin
            r = a - FULL_W;
        end
        else if (a <= -HALF_W)
        begin
            r = a + FULL_W;
        end
        return r;
    endfunction

    logic adv;
    logic out_valid_reg;

    // Square root stages
    logic [REM_W-1:0]        rem_reg [0:LAST];
    logic [ROOT_W-1:0]       q_reg   [0:LAST];
    logic [SQ_W-1:0]         sq_reg  [0:LAST];
    logic signed [SUM_W-1:0] ax_reg  [0:LAST];
    logic signed [SUM_W-1:0] mx_reg  [0:LAST];
    logic signed [SUM_W-1:0] my_reg  [0:LAST];
    logic                    vs_reg  [0:LAST];

    // CORDIC side band
    logic cv_reg    [0:STEPS];
    logic hzero_reg [0:STEPS];
    logic hneg_reg  [0:STEPS];

    logic signed [CORD_W-1:0]  ax_w, p_x, p_y, h_x, h_y;
    logic signed [ANGLE_W-1:0] p_ang, h_ang, pitch_c, head_sel;
    logic signed [WRAP_W-1:0]  head_w;

    logic                      vf1_reg;
    logic signed [PITCH_W-1:0] pitch_f1_reg;
    logic signed [HEAD_W-1:0]  head_f1_reg;

    logic signed [WRAP_W-1:0] lat_w, alat, ptol_w, htol_w, pw, lo, hi, tgt, diff, dabs;
    logic pok, hok;

    assign adv        = !out_valid_reg || result.ready;
    assign item_ready = adv;
    assign result.valid = out_valid_reg;

    for (genvar s = 0; s < SQRT_STEPS; s++)
    begin : g_sqrt
        localparam int K = SQRT_STEPS - 1 - s;
        logic [REM_W-1:0]        rem_c, remv, trial;
        logic [ROOT_W-1:0]       q_c;
        logic [SQ_W-1:0]         sq_c;
        logic signed [SUM_W-1:0] ax_c, mx_c, my_c;
        logic                    v_c;
        logic [1:0]              pair;

        if (s == 0)
        begin : g_src0
            assign rem_c = '0;
            assign q_c   = '0;
            assign sq_c  = item.sq;
            assign ax_c  = item.ax;
            assign mx_c  = item.mx;
            assign my_c  = item.my;
            assign v_c   = item_valid;
        end
        else
        begin : g_src
            assign rem_c = rem_reg[s-1];
            assign q_c   = q_reg[s-1];
            assign sq_c  = sq_reg[s-1];
            assign ax_c  = ax_reg[s-1];
            assign mx_c  = mx_reg[s-1];
            assign my_c  = my_reg[s-1];
            assign v_c   = vs_reg[s-1];
        end

        // The radicand is sq shifted up; its low bit pairs are zero.
        if (2 * K >= SQ_PRESHIFT)
        begin : g_pair
            assign pair = sq_c[2*K-SQ_PRESHIFT+1:2*K-SQ_PRESHIFT];
        end
        else
        begin : g_nopair
            assign pair = 2'b00;
        end

        assign remv  = {rem_c[REM_W-3:0], pair};
        assign trial = REM_W'({q_c, 2'b01});

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (remv >= trial)
                begin
                    rem_reg[s] <= remv - trial;
                    q_reg[s]   <= {q_c[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s] <= remv;
                    q_reg[s]   <= {q_c[ROOT_W-2:0], 1'b0};
                end
                sq_reg[s] <= sq_c;
                ax_reg[s] <= ax_c;
                mx_reg[s] <= mx_c;
                my_reg[s] <= my_c;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vs_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                vs_reg[s] <= v_c;
            end
        end
    end

    // Pitch: atan2(-ax * 2^15, root); heading: atan2(mx * 2^15, my * 2^15).
    assign ax_w = CORD_W'(ax_reg[LAST]);
    assign p_x  = CORD_W'(q_reg[LAST]);
    assign p_y  = -(ax_w <<< Q15_SHIFT);
    assign h_x  = CORD_W'(my_reg[LAST]) <<< Q15_SHIFT;
    assign h_y  = CORD_W'(mx_reg[LAST]) <<< Q15_SHIFT;

    tha_cordic #(.STEPS(STEPS)) u_pitch_cordic (
        .clk   (clk),
        .en    (adv),
        .x_in  (p_x),
        .y_in  (p_y),
        .angle (p_ang)
    );

    tha_cordic #(.STEPS(STEPS)) u_head_cordic (
        .clk   (clk),
        .en    (adv),
        .x_in  (h_x),
        .y_in  (h_y),
        .angle (h_ang)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hzero_reg[0] <= (my_reg[LAST] == '0);
            hneg_reg[0]  <= (mx_reg[LAST] < 0);
            for (int i = 0; i < STEPS; i++)
            begin
                hzero_reg[i+1] <= hzero_reg[i];
                hneg_reg[i+1]  <= hneg_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= STEPS; i++)
            begin
                cv_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            cv_reg[0] <= vs_reg[LAST];
            for (int i = 0; i < STEPS; i++)
            begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end
    end

    // Clamp pitch, pick the heading, remove declination and wrap.
    always_comb
    begin
        pitch_c = p_ang;
        if (p_ang > PLIM_A)
        begin
            pitch_c = PLIM_A;
        end
        else if (p_ang < -PLIM_A)
        begin
            pitch_c = -PLIM_A;
        end
        if (hzero_reg[STEPS])
        begin
            head_sel = hneg_reg[STEPS] ? HALF_A : '0;
        end
        else
        begin
            head_sel = h_ang;
        end
        head_w = wrap_once(WRAP_W'(head_sel) - WRAP_W'(cfg.declination));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pitch_f1_reg <= PITCH_W'(pitch_c);
            head_f1_reg  <= HEAD_W'(head_w);
        end
    end

    // Alignment windows.
    always_comb
    begin
        lat_w  = WRAP_W'(cfg.latitude);
        alat   = (lat_w < 0) ? -lat_w : lat_w;
        ptol_w = WRAP_W'(cfg.pitch_tol);
        htol_w = WRAP_W'(cfg.heading_tol);
        pw     = WRAP_W'(pitch_f1_reg);
        lo     = alat - ptol_w;
        hi     = alat + ptol_w;
        pok    = (pw >= lo) && (pw <= hi);
        tgt    = (lat_w <= 0) ? HALF_W : '0;
        diff   = wrap_once(WRAP_W'(head_f1_reg) - tgt);
        dabs   = (diff < 0) ? -diff : diff;
        hok    = (dabs <= htol_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf1_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vf1_reg       <= cv_reg[STEPS];
            out_valid_reg <= vf1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result.pitch_cdeg   <= pitch_f1_reg;
            result.heading_cdeg <= head_f1_reg;
            result.pitch_ok     <= pok;
            result.heading_ok   <= hok;
            result.all_ok       <= pok && hok;
        end
    end

    `THA_ASSERT_IMPL(a_pitch_range, out_valid_reg, (result.pitch_cdeg <= PITCH_W'(PITCH_LIMIT)) && (result.pitch_cdeg >= -PITCH_W'(PITCH_LIMIT)))
    `THA_ASSERT_IMPL(a_head_range, out_valid_reg, (result.heading_cdeg != HEAD_W'(-HALF_TURN)))
    `THA_ASSERT_IMPL(a_all_ok, out_valid_reg, result.all_ok == (result.pitch_ok && result.heading_ok))

endmodule

@@ bench/tb_tilt_heading_alignment_check.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Tilt and heading alignment check: testbench
// Drives raw sensor samples through the block under several register
// settings, predicts pitch, heading and alignment flags with an independent
// model and compares every result transaction in order.
// ============================================================================
module tb_tilt_heading_alignment_check;
    import tha_pkg::*;

    // Input sample as the driver sends it.
    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] mx;
        logic signed [15:0] my;
    } sample_t;

    // One expected or observed alignment result.
    typedef struct packed {
        logic signed [14:0] pitch;
        logic signed [15:0] heading;
        logic               pitch_ok;
        logic               heading_ok;
        logic               all_ok;
    } align_t;

    localparam int DRAIN_CYCLES = CORDIC_STEPS_DEF + 60;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tha_sample_if sample_ch();
    tha_result_if result_ch();

    tilt_heading_alignment_check dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch.sink),
        .result    (result_ch.source)
    );

    // The predictor keeps its own copy of the registers.
    cfg_t    site_cfg;
    sample_t pending_samples[$];
    align_t  expected_alignments[$];
    int      mismatch_count;
    int      unexpected_count;
    bit      idle_off;    // set during the stretch where neither side idles

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Safety net: ends the run if the block hangs.
    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    // Arithmetic shift right with floor semantics on 64-bit values.
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    // Vectoring CORDIC arctangent of yv/xv in whole centidegrees.
    function automatic longint angle_of(longint yv, longint xv);
        longint ang;
        longint nx;
        longint step_tab[16];
        step_tab = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
                     5730, 2865, 1432, 716, 358, 179, 90, 45};
        ang = 0;
        if (xv == 0 && yv == 0) return 0;
        // Left half plane: rotate by half a turn first.
        if (xv < 0) begin
            ang = (yv >= 0) ? 64'sd4608000 : -64'sd4608000;
            xv  = -xv;
            yv  = -yv;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            if (yv > 0) begin
                nx  = xv + shr_floor(yv, i);
                yv  = yv - shr_floor(xv, i);
                ang += step_tab[i];
            end else begin
                nx  = xv - shr_floor(yv, i);
                yv  = yv + shr_floor(xv, i);
                ang -= step_tab[i];
            end
            xv = nx;
        end
        return shr_floor(ang + 128, 8);
    endfunction

    function automatic longint wrap_angle(longint a);
        while (a > 18000) a -= 36000;
        while (a <= -18000) a += 36000;
        return a;
    endfunction

    function automatic align_t predict_alignment(sample_t s, cfg_t c);
        longint ax, ay, az, mx, my, root, pitch, head, alat, diff;
        longint unsigned sq;
        align_t r;
        ax = longint'(s.ax) + c.offset_x;
        ay = longint'(s.ay) + c.offset_y;
        az = longint'(s.az) + c.offset_z;
        mx = longint'(s.mx) + c.offset_x;
        my = longint'(s.my) + c.offset_y;
        sq = longint'(ay * ay + az * az);
        root  = int_sqrt(sq << 30);
        pitch = angle_of(-ax * 32768, root);
        if (pitch > 9000) pitch = 9000;
        if (pitch < -9000) pitch = -9000;
        // A zero y axis points straight along x.
        if (my == 0) head = (mx < 0) ? 18000 : 0;
        else head = angle_of(mx * 32768, my * 32768);
        head = wrap_angle(head - longint'(c.declination));
        alat = (c.latitude < 0) ? -longint'(c.latitude) : longint'(c.latitude);
        r.pitch_ok = (pitch >= alat - longint'(c.pitch_tol))
                     && (pitch <= alat + longint'(c.pitch_tol));
        // Southern or equatorial sites align to south, northern ones to north.
        diff = wrap_angle(head - ((c.latitude <= 0) ? 18000 : 0));
        if (diff < 0) diff = -diff;
        r.heading_ok = diff <= longint'(c.heading_tol);
        r.all_ok     = r.pitch_ok && r.heading_ok;
        r.pitch      = pitch[14:0];
        r.heading    = head[15:0];
        return r;
    endfunction

    // Driver: pops the next sample once the current transaction is taken.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sample_ch.valid   <= 1'b0;
            sample_ch.accel_x <= '0;
            sample_ch.accel_y <= '0;
            sample_ch.accel_z <= '0;
            sample_ch.mag_x   <= '0;
            sample_ch.mag_y   <= '0;
        end else if (!sample_ch.valid || sample_ch.ready) begin
            if (pending_samples.size() > 0 && (idle_off || $urandom_range(99) >= 26)) begin
                sample_t s;
                s = pending_samples.pop_front();
                expected_alignments.push_back(predict_alignment(s, site_cfg));
                sample_ch.valid   <= 1'b1;
                sample_ch.accel_x <= s.ax;
                sample_ch.accel_y <= s.ay;
                sample_ch.accel_z <= s.az;
                sample_ch.mag_x   <= s.mx;
                sample_ch.mag_y   <= s.my;
            end else begin
                sample_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: stalls the result side at random and checks each transaction.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                align_t got, want;
                got = '{result_ch.pitch_cdeg, result_ch.heading_cdeg, result_ch.pitch_ok,
                        result_ch.heading_ok, result_ch.all_ok};
                if (expected_alignments.size() == 0) begin
                    unexpected_count++;
                    $display("unexpected result transaction %p", got);
                end else begin
                    want = expected_alignments.pop_front();
                    if (got !== want) begin
                        if (mismatch_count < 10)
                            $display("mismatch: expected %p, got %p", want, got);
                        mismatch_count++;
                    end
                end
            end
            result_ch.ready <= idle_off || ($urandom_range(99) >= 26);
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Writes all registers to both the block and the predictor's copy.
    task automatic apply_site(logic signed [15:0] ox, logic signed [15:0] oy,
                              logic signed [15:0] oz, logic signed [15:0] decl,
                              logic signed [14:0] lat, logic [13:0] ptol, logic [14:0] htol);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_OFFSET_Z, oz);
        write_reg(CFG_DECLINATION, decl);
        write_reg(CFG_LATITUDE, {lat[14], lat});
        write_reg(CFG_PITCH_TOL, {2'b00, ptol});
        write_reg(CFG_HEADING_TOL, {1'b0, htol});
        site_cfg = '{ox, oy, oz, decl, lat, ptol, htol};
    endtask

    // Waits until every sample is sent and every result has come back.
    task automatic drain();
        while (pending_samples.size() > 0 || sample_ch.valid || expected_alignments.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    // Mostly small offsets so the sums stay well spread; sometimes full range.
    function automatic logic signed [15:0] rnd_offset();
        if ($urandom_range(3) == 0) return rnd16();
        return 16'($signed($urandom_range(2000)) - 1000);
    endfunction

    initial begin
        sample_t s;
        logic signed [15:0] ext[4];
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        idle_off  = 1'b0;
        site_cfg  = '0;
        mismatch_count   = 0;
        unexpected_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, zero vector, zero magnetometer y in both
        // signs, exact half turn, with reset registers.
        ext = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1};
        for (int i = 0; i < 4; i++)
            pending_samples.push_back('{ext[i], ext[(i+1)%4], ext[(i+2)%4],
                                        ext[(i+3)%4], ext[i]});
        pending_samples.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        pending_samples.push_back('{16'sd100, 16'sd0, 16'sd0, -16'sd50, 16'sd0});
        pending_samples.push_back('{-16'sd100, 16'sd3, 16'sd4, 16'sd50, 16'sd0});
        pending_samples.push_back('{16'sd0, 16'sd0, 16'sd1000, 16'sd0, -16'sd700});
        pending_samples.push_back('{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        pending_samples.push_back('{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        drain();

        // Extreme register values, including out-of-range declination and
        // offsets that push sums past 16 bits.
        apply_site(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, -15'sd9000, 14'd9000, 15'd18000);
        pending_samples.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh0000});
        pending_samples.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8001, 16'sh8000});
        pending_samples.push_back('{16'sd0, 16'sh8000, 16'sd0, 16'sh7fff, 16'sh7fff});
        drain();
        apply_site(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 15'sd9000, 14'd0, 15'd0);
        pending_samples.push_back('{16'sh7fff, 16'sh8001, 16'sh7fff, 16'sh7fff, 16'sh8001});
        pending_samples.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        drain();

        // Random phases under several settings; the third has no idling.
        for (int ph = 0; ph < 6; ph++) begin
            apply_site(rnd_offset(), rnd_offset(), rnd_offset(),
                       (ph == 1) ? rnd16() : 16'($signed($urandom_range(36000)) - 18000),
                       (ph == 4) ? 15'sd0 : 15'($signed($urandom_range(18000)) - 9000),
                       14'($urandom_range(9000)), 15'($urandom_range(18000)));
            idle_off = (ph == 2);
            for (int n = 0; n < 85; n++) begin
                if ($urandom_range(4) == 0) begin
                    // Small values so offsets and zero axes interact.
                    s = '{16'($signed($urandom_range(8)) - 4), 16'($signed($urandom_range(8)) - 4),
                          16'($signed($urandom_range(8)) - 4), 16'($signed($urandom_range(8)) - 4),
                          16'($signed($urandom_range(8)) - 4)};
                    if ($urandom_range(1)) s.my = -site_cfg.offset_y;
                end else begin
                    s = '{rnd16(), rnd16(), rnd16(), rnd16(), rnd16()};
                end
                pending_samples.push_back(s);
            end
            drain();
        end

        if (mismatch_count == 0 && unexpected_count == 0 && expected_alignments.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
